FILE: sv/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg: shared definitions for the permutation rank / unrank block
// Field widths, default size, opcodes, factorial helper and the control group
// that travels along the chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pru_pkg;

    // Fixed field widths of the transaction payload.
    localparam int RANK_W  = 19;
    localparam int PERM_W  = 36;
    localparam int DIGIT_W = 4;

    // Default number of elements in a permutation.
    localparam int NUM_ELEMENTS_DEF = 9;

    // Operation codes.
    localparam logic OP_RANK   = 1'b0;
    localparam logic OP_UNRANK = 1'b1;

    // Control group that moves with each transaction from cell to cell.
    typedef struct packed {
        logic vld;
        logic op;
        logic bad;
    } pru_ctl_t;

    // Factorial, evaluated at elaboration only.
    function automatic longint unsigned fact(input int n);
        longint unsigned f;
        f = 1;
        for (int i = 2; i <= n; i++)
        begin
            f = f * longint'(i);
        end
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pru_cell.sv
// ----------------------------------------------------------------------------
// pru_cell: one position of the rank / unrank chain
// Handles the digit at position POS. For rank it checks the digit, counts the
// later smaller digits and adds their weighted count. For unrank it takes one
// factorial digit off the remainder and writes the selected unused value.
// ----------------------------------------------------------------------------
`default_nettype none

module pru_cell
    import pru_pkg::*;
#(
    parameter int N   = NUM_ELEMENTS_DEF,
    parameter int POS = 0,
    parameter int RW  = RANK_W
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire pru_ctl_t               ctl_in,
    input  wire logic [N-1:0]           used_in,
    input  wire logic [RW-1:0]          num_in,
    input  wire logic [N*DIGIT_W-1:0]   word_in,
    output pru_ctl_t                    ctl_out,
    output logic      [N-1:0]           used_out,
    output logic      [RW-1:0]          num_out,
    output logic      [N*DIGIT_W-1:0]   word_out
);

    localparam int          SH = DIGIT_W * (N - 1 - POS);
    localparam int          NL = N - 1 - POS;
    localparam logic [RW-1:0] W = RW'(fact(NL));

    pru_ctl_t               ctl_reg,  ctl_next;
    logic [N-1:0]           used_reg, used_next;
    logic [RW-1:0]          num_reg,  num_next;
    logic [N*DIGIT_W-1:0]   word_reg, word_next;

    logic [DIGIT_W-1:0]     dig;
    logic [DIGIT_W-1:0]     cnt;
    logic [DIGIT_W-1:0]     kdig;
    logic [DIGIT_W-1:0]     below;
    logic [DIGIT_W-1:0]     pick;
    logic                   seen;
    logic                   out_of_range;
    logic [N-1:0]           dig_hot;

    assign dig = word_in[SH +: DIGIT_W];

    // Rank path: validity of this digit and count of later smaller digits.
    always_comb
    begin
        seen    = 1'b0;
        dig_hot = '0;
        cnt     = '0;
        for (int v = 0; v < N; v++)
        begin
            if (dig == DIGIT_W'(v + 1))
            begin
                dig_hot[v] = 1'b1;
                if (used_in[v])
                begin
                    seen = 1'b1;
                end
            end
        end
        for (int j = POS + 1; j < N; j++)
        begin
            if (word_in[DIGIT_W*(N-1-j) +: DIGIT_W] < dig)
            begin
                cnt = cnt + DIGIT_W'(1);
            end
        end
    end

    assign out_of_range = (dig == '0) || (dig > DIGIT_W'(N));

    // Unrank path: factorial digit by compare against constant multiples,
    // then the unused value with exactly that many unused values below it.
    always_comb
    begin
        kdig = '0;
        pick = '0;
        for (int j = 1; j <= NL; j++)
        begin
            if (num_in >= RW'(j) * W)
            begin
                kdig = kdig + DIGIT_W'(1);
            end
        end
        for (int v = 0; v < N; v++)
        begin
            below = '0;
            for (int u = 0; u < v; u++)
            begin
                if (!used_in[u])
                begin
                    below = below + DIGIT_W'(1);
                end
            end
            if (!used_in[v] && below == kdig)
            begin
                pick = DIGIT_W'(v + 1);
            end
        end
    end

    // Next values for the stage register.
    always_comb
    begin
        ctl_next  = ctl_in;
        used_next = used_in;
        num_next  = num_in;
        word_next = word_in;
        if (ctl_in.op == OP_RANK)
        begin
            ctl_next.bad = ctl_in.bad | out_of_range | seen;
            used_next    = used_in | dig_hot;
            num_next     = num_in + RW'(cnt) * W;
        end
        else
        begin
            used_next = used_in;
            for (int v = 0; v < N; v++)
            begin
                if (pick == DIGIT_W'(v + 1))
                begin
                    used_next[v] = 1'b1;
                end
            end
            num_next               = num_in - RW'(kdig) * W;
            word_next[SH +: DIGIT_W] = pick;
        end
    end

    // Control register of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Payload registers of the stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            used_reg <= used_next;
            num_reg  <= num_next;
            word_reg <= word_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign used_out = used_reg;
    assign num_out  = num_reg;
    assign word_out = word_reg;

endmodule

`default_nettype wire

FILE: sv/permutation_rank_unrank.sv
// ----------------------------------------------------------------------------
// permutation_rank_unrank: Cantor expansion rank and unrank of permutations
// Converts a permutation of 1..NUM_ELEMENTS to its lexicographic rank, or a
// rank back to the permutation, in a chain of one cell per position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries opcode, perm_digits and
//   rank_in. Opcode OP_RANK ranks perm_digits, OP_UNRANK unranks rank_in.
//   Output channel (out_valid / out_ready) carries rank_out, perm_out and
//   bad_input; each input transaction gives exactly one output transaction.
//   There is one register stage per cell and one cell per permutation position.
//   Throughput is one transaction per cycle while the receiver keeps up.
//   A bad input (digits not a permutation, or a rank of NUM_ELEMENTS! or more)
//   sets bad_input with both rank_out and perm_out zero.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   in_ready drops; in_ready is high whenever the last cell is empty or its
//   transaction is taken in the same cycle.
//   Reset clears all stage valid bits; the payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_rank_unrank
    import pru_pkg::*;
#(
    parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               opcode,
    input  wire logic [PERM_W-1:0]  perm_digits,
    input  wire logic [RANK_W-1:0]  rank_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [RANK_W-1:0]       rank_out,
    output logic [PERM_W-1:0]       perm_out,
    output logic                    bad_input
);

    localparam int N    = NUM_ELEMENTS;
    localparam int PW   = N * DIGIT_W;
    localparam int FW   = $clog2(fact(N) + 1);
    localparam int RW   = (FW > RANK_W) ? FW : RANK_W;
    localparam logic [RW-1:0] FACT_N = RW'(fact(N));

    pru_ctl_t               ctl_c  [N+1];
    logic [N-1:0]           used_c [N];
    logic [RW-1:0]          num_c  [N+1];
    logic [PW-1:0]          word_c [N+1];
    logic                   adv;

    // The chain moves whenever the last cell is empty or being drained.
    assign adv      = !ctl_c[N].vld || out_ready;
    assign in_ready = adv;

    // Entry into the first cell; unrank starts from an empty word.
    always_comb
    begin
        ctl_c[0].vld = in_valid;
        ctl_c[0].op  = opcode;
        ctl_c[0].bad = (opcode == OP_UNRANK) && (RW'(rank_in) >= FACT_N);
        used_c[0]    = '0;
        num_c[0]     = (opcode == OP_UNRANK) ? RW'(rank_in) : '0;
        word_c[0]    = (opcode == OP_UNRANK) ? '0 : PW'(perm_digits);
    end

    // One cell per permutation position.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        if (i < N - 1)
        begin : g_mid
            pru_cell #(
                .N   (N),
                .POS (i),
                .RW  (RW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (adv),
                .ctl_in   (ctl_c[i]),
                .used_in  (used_c[i]),
                .num_in   (num_c[i]),
                .word_in  (word_c[i]),
                .ctl_out  (ctl_c[i+1]),
                .used_out (used_c[i+1]),
                .num_out  (num_c[i+1]),
                .word_out (word_c[i+1])
            );
        end
        else
        begin : g_last
            pru_cell #(
                .N   (N),
                .POS (i),
                .RW  (RW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (adv),
                .ctl_in   (ctl_c[i]),
                .used_in  (used_c[i]),
                .num_in   (num_c[i]),
                .word_in  (word_c[i]),
                .ctl_out  (ctl_c[i+1]),
                .used_out (),
                .num_out  (num_c[i+1]),
                .word_out (word_c[i+1])
            );
        end
    end

    // Result from the last cell; outputs not meant for the operation are zero.
    always_comb
    begin
        out_valid = ctl_c[N].vld;
        bad_input = ctl_c[N].bad;
        rank_out  = '0;
        perm_out  = '0;
        if (!ctl_c[N].bad)
        begin
            if (ctl_c[N].op == OP_RANK)
            begin
                rank_out = RANK_W'(num_c[N]);
            end
            else
            begin
                perm_out = PERM_W'(word_c[N]);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/pru_checker.sv
// ----------------------------------------------------------------------------
// pru_checker: port level checks for permutation_rank_unrank
// Watches the top level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
`default_nettype none

module pru_checker
    import pru_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               opcode,
    input  wire logic [PERM_W-1:0]  perm_digits,
    input  wire logic [RANK_W-1:0]  rank_in,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [RANK_W-1:0]  rank_out,
    input  wire logic [PERM_W-1:0]  perm_out,
    input  wire logic               bad_input
);

    // The chain only stalls when a result is waiting and not taken.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stage");

    // A rejected transaction carries zero in both result fields.
    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_input) |-> (rank_out == '0 && perm_out == '0))
    else $error("bad_input result with nonzero payload");

    // Only one of the two result fields can be nonzero.
    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rank_out == '0 || perm_out == '0))
    else $error("rank_out and perm_out both nonzero");

    // A stalled result stays put.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(rank_out)
            && $stable(perm_out) && $stable(bad_input)))
    else $error("output changed while stalled");

endmodule

bind permutation_rank_unrank pru_checker u_pru_checker (.*);

`default_nettype wire

FILE: tb/sv/pru_rank_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pru_rank_checker: result checker for the permutation rank / unrank block
// Watches both channels. Every accepted input transaction is converted into
// its expected result by an independent rank / unrank calculation, and every
// accepted output transaction is compared field by field with the oldest
// expected result. The failure count and the number of results still
// outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------

module pru_rank_checker
    import pru_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              opcode,
    input  wire logic [PERM_W-1:0] perm_digits,
    input  wire logic [RANK_W-1:0] rank_in,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [RANK_W-1:0] rank_out,
    input  wire logic [PERM_W-1:0] perm_out,
    input  wire logic              bad_input,
    output int                     fail_count,
    output int                     results_pending
);

    localparam int N = NUM_ELEMENTS_DEF;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [PERM_W-1:0] perm;
        logic              bad;
    } pru_result_t;

    pru_result_t pending_results[$];

    // Weight of one Lehmer digit: the factorial of the positions after it.
    function automatic int unsigned position_weight(input int n);
        int unsigned w;
        w = 1;
        for (int i = 2; i <= n; i++)
        begin
            w = w * i;
        end
        return w;
    endfunction

    // Rank of a permutation of 1..N, or a rejection.
    function automatic pru_result_t rank_permutation(input logic [PERM_W-1:0] digits);
        pru_result_t  r;
        logic [3:0]   d [N];
        logic [15:0]  seen;
        int unsigned  acc;
        int unsigned  smaller;
        r    = '0;
        seen = '0;
        acc  = 0;
        for (int i = 0; i < N; i++)
        begin
            d[i] = digits[DIGIT_W*(N-1-i) +: DIGIT_W];
            if (d[i] == 4'd0 || d[i] > N || seen[d[i]])
            begin
                r.bad = 1'b1;
            end
            seen[d[i]] = 1'b1;
        end
        if (!r.bad)
        begin
            for (int i = 0; i < N; i++)
            begin
                smaller = 0;
                for (int j = i + 1; j < N; j++)
                begin
                    if (d[i] > d[j])
                    begin
                        smaller++;
                    end
                end
                acc = acc + smaller * position_weight(N - 1 - i);
            end
            r.rank = acc[RANK_W-1:0];
        end
        return r;
    endfunction

    // Permutation at a given lexicographic rank, or a rejection.
    function automatic pru_result_t unrank_permutation(input logic [RANK_W-1:0] rk);
        pru_result_t  r;
        logic [15:0]  used;
        int unsigned  rest;
        int unsigned  w;
        int unsigned  k;
        int           pick;
        r    = '0;
        used = '0;
        rest = 32'(rk);
        if (rest >= position_weight(N))
        begin
            r.bad = 1'b1;
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                w    = position_weight(N - 1 - i);
                k    = rest / w;
                rest = rest % w;
                pick = 0;
                // The factorial digit selects the k-th value not yet used.
                for (int v = 1; v <= N; v++)
                begin
                    if (!used[v] && pick == 0)
                    begin
                        if (k == 0)
                        begin
                            pick = v;
                        end
                        else
                        begin
                            k--;
                        end
                    end
                end
                used[pick] = 1'b1;
                r.perm[DIGIT_W*(N-1-i) +: DIGIT_W] = 4'(pick);
            end
        end
        return r;
    endfunction

    // Predict on input transactions, compare on output transactions.
    always @(posedge clk)
    begin
        pru_result_t want;
        if (!rst_n)
        begin
            fail_count      = 0;
            results_pending = 0;
            pending_results.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (opcode == OP_RANK)
                begin
                    pending_results.push_back(rank_permutation(perm_digits));
                end
                else
                begin
                    pending_results.push_back(unrank_permutation(rank_in));
                end
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: unexpected result rank_out=%0d perm_out=%h %s%b",
                                 $time, rank_out, perm_out, "bad_input=", bad_input);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rank_out !== want.rank || perm_out !== want.perm
                        || bad_input !== want.bad)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch rank_out exp %0d got %0d,",
                                     $time, want.rank, rank_out);
                            $display("    perm_out exp %h got %h, bad_input exp %b got %b",
                                     want.perm, perm_out, want.bad, bad_input);
                        end
                    end
                end
            end
            results_pending = pending_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_permutation_rank_unrank.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_permutation_rank_unrank: testbench for the permutation rank / unrank block
// Sends a directed set of corner cases, then about 1550 random transactions
// that are mostly valid permutations and ranks, mixed with broken digit sets
// and out-of-range ranks. Both channels idle in random bursts; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_permutation_rank_unrank;
    import pru_pkg::*;

    localparam int N           = NUM_ELEMENTS_DEF;
    localparam int RANDOM_XACT = 1550;
    localparam int CALM_TAIL   = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_RANK    = 362879;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              opcode;
    logic [PERM_W-1:0] perm_digits;
    logic [RANK_W-1:0] rank_in;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [RANK_W-1:0] rank_out;
    logic [PERM_W-1:0] perm_out;
    logic              bad_input;
    int                fail_count;
    int                results_pending;

    int idle_pct;
    int stall_left = 0;
    int cycle_count = 0;
    int n_rank_sent;
    int n_unrank_sent;
    int n_reject_sent;

    permutation_rank_unrank u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .perm_digits (perm_digits),
        .rank_in     (rank_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rank_out    (rank_out),
        .perm_out    (perm_out),
        .bad_input   (bad_input)
    );

    pru_rank_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .perm_digits     (perm_digits),
        .rank_in         (rank_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rank_out        (rank_out),
        .perm_out        (perm_out),
        .bad_input       (bad_input),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, results_pending);
            $display("FAIL permutation_rank_unrank");
            $finish;
        end
    end

    // Receiver stalls in bursts of random length.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // A random permutation of 1..N, packed with the first position on top.
    function automatic logic [PERM_W-1:0] shuffled_digits();
        logic [3:0]        vals [N];
        logic [3:0]        tmp;
        logic [PERM_W-1:0] p;
        int                j;
        p = '0;
        for (int i = 0; i < N; i++)
        begin
            vals[i] = 4'(i + 1);
        end
        for (int i = N - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
        for (int i = 0; i < N; i++)
        begin
            p[DIGIT_W*(N-1-i) +: DIGIT_W] = vals[i];
        end
        return p;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_xact(input logic op, input logic [PERM_W-1:0] digits,
                             input logic [RANK_W-1:0] rk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        perm_digits <= digits;
        rank_in     <= rk;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (op == OP_RANK)
        begin
            n_rank_sent++;
        end
        else
        begin
            n_unrank_sent++;
        end
    endtask

    initial
    begin
        logic [PERM_W-1:0] digits;
        logic [RANK_W-1:0] rk;
        int                pick;
        int                pos;
        int                other;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = OP_RANK;
        perm_digits = '0;
        rank_in     = '0;
        idle_pct    = 15;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corner cases: first and last ranks, rejections of every
        // kind, and the unused field at its extremes.
        send_xact(OP_RANK,   36'h123456789, '0);
        send_xact(OP_RANK,   36'h987654321, '1);
        send_xact(OP_RANK,   36'h213456789, 19'd5);
        send_xact(OP_RANK,   36'h918273645, 19'd362880);
        send_xact(OP_UNRANK, '0, 19'd0);
        send_xact(OP_UNRANK, '1, 19'd362879);
        send_xact(OP_UNRANK, 36'h123456789, 19'd1);
        send_xact(OP_UNRANK, 36'h555555555, 19'd262144);
        send_xact(OP_UNRANK, '0, 19'd12345);
        send_xact(OP_UNRANK, '0, 19'd362880);
        send_xact(OP_UNRANK, '1, '1);
        send_xact(OP_RANK,   '0, 19'd0);
        send_xact(OP_RANK,   '1, 19'd0);
        send_xact(OP_RANK,   36'h123456780, 19'd0);
        send_xact(OP_RANK,   36'h12345678A, 19'd0);
        send_xact(OP_RANK,   36'hF23456789, 19'd0);
        send_xact(OP_RANK,   36'h123456788, 19'd0);
        send_xact(OP_RANK,   36'h111111111, 19'd0);
        n_reject_sent = 9;

        // Random part: mostly valid permutations and ranks with random
        // content, the rest broken digit sets, noise and oversized ranks.
        for (int n = 0; n < RANDOM_XACT; n++)
        begin
            if (n >= RANDOM_XACT - CALM_TAIL)
            begin
                idle_pct = 0;
            end
            else if (n % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 50;
                endcase
            end
            digits = PERM_W'({$urandom(), $urandom()});
            rk     = RANK_W'($urandom());
            pick   = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_xact(OP_RANK, shuffled_digits(), rk);
            end
            else if (pick < 75)
            begin
                send_xact(OP_UNRANK, digits, 19'($urandom_range(0, MAX_RANK)));
            end
            else if (pick < 85)
            begin
                // One nibble overwritten with any value.
                digits = shuffled_digits();
                pos    = $urandom_range(0, N - 1);
                digits[DIGIT_W*pos +: DIGIT_W] = 4'($urandom_range(0, 15));
                send_xact(OP_RANK, digits, rk);
                n_reject_sent++;
            end
            else if (pick < 90)
            begin
                send_xact(OP_RANK, digits, rk);
                n_reject_sent++;
            end
            else if (pick < 97)
            begin
                send_xact(OP_UNRANK, digits, 19'($urandom_range(MAX_RANK + 1, 524287)));
                n_reject_sent++;
            end
            else
            begin
                // One digit copied over another, giving a repeat.
                digits = shuffled_digits();
                pos    = $urandom_range(0, N - 1);
                other  = (pos + $urandom_range(1, N - 1)) % N;
                digits[DIGIT_W*other +: DIGIT_W] = digits[DIGIT_W*pos +: DIGIT_W];
                send_xact(OP_RANK, digits, rk);
                n_reject_sent++;
            end
        end
        in_valid <= 1'b0;

        // Drain, then give a stray result time to show up.
        while (results_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (N + 8) @(posedge clk);

        $display("Sent %0d rank and %0d unrank transactions, %0d of them built as rejects,",
                 n_rank_sent, n_unrank_sent, n_reject_sent);
        $display("with bursts of idling on both channels and %0d failures.", fail_count);
        if (fail_count == 0)
        begin
            $display("PASS permutation_rank_unrank");
        end
        else
        begin
            $display("FAIL permutation_rank_unrank");
        end
        $finish;
    end

endmodule
